// ----- hw/rtl/mmbl_pkg.sv -----
// ============================================================================
// mmbl_pkg
// Shared types, constants and helper functions of the min-max bounding-box
// localizer: payload structs, request and register codes, saturation helpers.
// ============================================================================
`default_nettype none

package mmbl_pkg;

    // Widths
    localparam int COORD_WIDTH    = 24;
    localparam int COUNT_WIDTH    = 8;
    localparam int IN_COORD_WIDTH = 24;
    localparam int EXTENT_WIDTH   = 23;
    localparam int HALF_WIDTH     = 22;
    // Working width for sums before saturation
    localparam int EXT_WIDTH =
        ((COORD_WIDTH > IN_COORD_WIDTH) ? COORD_WIDTH : IN_COORD_WIDTH) + 2;

    // APB port
    localparam int APB_ADDR_WIDTH = 4;
    localparam int APB_DATA_WIDTH = 32;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    // Register reset values
    localparam logic [EXTENT_WIDTH-1:0] FIELD_WIDTH_RST    = 23'd16000;
    localparam logic [EXTENT_WIDTH-1:0] FIELD_HEIGHT_RST   = 23'd16000;
    localparam logic [HALF_WIDTH-1:0]   ANCHOR_HALF_RST    = 22'd1600;
    localparam logic [HALF_WIDTH-1:0]   NEGATIVE_HALF_RST  = 22'd1200;

    // Anchors plus neighbours needed before an estimate is issued
    localparam int ESTIMATE_MIN_COUNT = 2;

    // Corner masks of the kept box found inside a negative box
    // bit 0: (xmin,ymin), bit 1: (xmax,ymin), bit 2: (xmin,ymax), bit 3: (xmax,ymax)
    localparam logic [3:0] CORNERS_BOTTOM = 4'b0011;
    localparam logic [3:0] CORNERS_LEFT   = 4'b0101;
    localparam logic [3:0] CORNERS_RIGHT  = 4'b1010;
    localparam logic [3:0] CORNERS_TOP    = 4'b1100;
    localparam logic [3:0] CORNERS_ALL    = 4'b1111;

    typedef enum logic [1:0] {
        REQ_ANCHOR    = 2'd0,
        REQ_NEIGHBOUR = 2'd1,
        REQ_NEGATIVE  = 2'd2,
        REQ_RESERVED  = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        REG_FIELD_WIDTH   = 2'd0,
        REG_FIELD_HEIGHT  = 2'd1,
        REG_ANCHOR_HALF   = 2'd2,
        REG_NEGATIVE_HALF = 2'd3
    } reg_index_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [EXT_WIDTH-1:0]   ext_t;
    typedef logic [COUNT_WIDTH-1:0]        count_t;

    typedef struct packed {
        coord_t xmin;
        coord_t xmax;
        coord_t ymin;
        coord_t ymax;
    } box_t;

    // Input transaction
    typedef struct packed {
        logic [1:0]                         req_type;
        logic signed [IN_COORD_WIDTH-1:0]   anchor_x;
        logic signed [IN_COORD_WIDTH-1:0]   anchor_y;
    } req_t;

    // Result transaction
    typedef struct packed {
        coord_t box_xmin;
        coord_t box_xmax;
        coord_t box_ymin;
        coord_t box_ymax;
        coord_t estimate_x;
        coord_t estimate_y;
        logic   estimate_valid;
        logic   unlocalizable;
    } rsp_t;

    // Configuration registers
    typedef struct packed {
        logic [EXTENT_WIDTH-1:0] field_width;
        logic [EXTENT_WIDTH-1:0] field_height;
        logic [HALF_WIDTH-1:0]   anchor_half_side;
        logic [HALF_WIDTH-1:0]   negative_half_side;
    } cfg_t;

    // Box reload on extent write
    typedef struct packed {
        logic                    load_x;
        logic                    load_y;
        logic [EXTENT_WIDTH-1:0] extent;
    } reload_t;

    // Classified item from front to back
    typedef struct packed {
        req_kind_t kind;
        box_t      sq;
    } entry_t;

    // Clamp a working-width value to the coordinate range
    function automatic coord_t sat_coord(input ext_t v);
        logic [EXT_WIDTH-COORD_WIDTH:0] top;
        coord_t                         r;
        top = v[EXT_WIDTH-1:COORD_WIDTH-1];
        if ((&top) || (~|top))
            r = v[COORD_WIDTH-1:0];
        else if (v[EXT_WIDTH-1])
            r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        else
            r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        return r;
    endfunction

    function automatic ext_t sext_coord(input coord_t v);
        return {{(EXT_WIDTH-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
    endfunction

    function automatic coord_t extent_to_coord(input logic [EXTENT_WIDTH-1:0] v);
        return sat_coord({{(EXT_WIDTH-EXTENT_WIDTH){1'b0}}, v});
    endfunction

    function automatic coord_t smax(input coord_t a, input coord_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic coord_t smin(input coord_t a, input coord_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic pt_in(input coord_t px, input coord_t py, input box_t b);
        return (px >= b.xmin) && (px <= b.xmax) && (py >= b.ymin) && (py <= b.ymax);
    endfunction

    // Corner-containment overlap test of box b against kept box s
    function automatic logic boxes_meet(input box_t b, input box_t s);
        return pt_in(b.xmin, b.ymin, s) || pt_in(b.xmin, b.ymax, s) ||
               pt_in(b.xmax, b.ymin, s) || pt_in(b.xmax, b.ymax, s) ||
               pt_in(s.xmin, s.ymin, b) || pt_in(s.xmin, s.ymax, b) ||
               pt_in(s.xmax, s.ymin, b) || pt_in(s.xmax, s.ymax, b);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mmbl_regs.sv -----
// ============================================================================
// mmbl_regs
// APB register file: playground extents and box half-sides, with a reload
// strobe for the kept box when an extent is written.
// ============================================================================
`default_nettype none

module mmbl_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mmbl_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  wire logic [mmbl_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic      [mmbl_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                     pready,
    output mmbl_pkg::cfg_t                           cfg,
    output mmbl_pkg::reload_t                        reload
);

    mmbl_pkg::cfg_t         cfg_reg;
    mmbl_pkg::cfg_t         cfg_next;
    mmbl_pkg::reg_index_t   index;
    logic                   wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = mmbl_pkg::reg_index_t'(paddr[mmbl_pkg::APB_ADDR_WIDTH-1:2]);
    assign cfg    = cfg_reg;

    // Write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        reload   = '0;
        reload.extent = pwdata[mmbl_pkg::EXTENT_WIDTH-1:0];
        if (wr_en)
        begin
            unique case (index)
                mmbl_pkg::REG_FIELD_WIDTH:
                begin
                    cfg_next.field_width = pwdata[mmbl_pkg::EXTENT_WIDTH-1:0];
                    reload.load_x        = 1'b1;
                end
                mmbl_pkg::REG_FIELD_HEIGHT:
                begin
                    cfg_next.field_height = pwdata[mmbl_pkg::EXTENT_WIDTH-1:0];
                    reload.load_y         = 1'b1;
                end
                mmbl_pkg::REG_ANCHOR_HALF:
                    cfg_next.anchor_half_side = pwdata[mmbl_pkg::HALF_WIDTH-1:0];
                mmbl_pkg::REG_NEGATIVE_HALF:
                    cfg_next.negative_half_side = pwdata[mmbl_pkg::HALF_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (index)
            mmbl_pkg::REG_FIELD_WIDTH:
                prdata = mmbl_pkg::APB_DATA_WIDTH'(cfg_reg.field_width);
            mmbl_pkg::REG_FIELD_HEIGHT:
                prdata = mmbl_pkg::APB_DATA_WIDTH'(cfg_reg.field_height);
            mmbl_pkg::REG_ANCHOR_HALF:
                prdata = mmbl_pkg::APB_DATA_WIDTH'(cfg_reg.anchor_half_side);
            mmbl_pkg::REG_NEGATIVE_HALF:
                prdata = mmbl_pkg::APB_DATA_WIDTH'(cfg_reg.negative_half_side);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.field_width        <= mmbl_pkg::FIELD_WIDTH_RST;
            cfg_reg.field_height       <= mmbl_pkg::FIELD_HEIGHT_RST;
            cfg_reg.anchor_half_side   <= mmbl_pkg::ANCHOR_HALF_RST;
            cfg_reg.negative_half_side <= mmbl_pkg::NEGATIVE_HALF_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mmbl_front.sv -----
// ============================================================================
// mmbl_front
// Input stage: takes request transactions, decodes the type, saturates the
// anchor position and builds the anchor or negative square box.
// ============================================================================
`default_nettype none

module mmbl_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire mmbl_pkg::req_t  req_data,
    input  wire mmbl_pkg::cfg_t  cfg,
    input  wire logic            q_full,
    output logic                 push,
    output mmbl_pkg::entry_t     push_entry
);

    logic                 valid_reg;
    logic                 valid_next;
    mmbl_pkg::entry_t     entry_reg;
    mmbl_pkg::entry_t     entry_next;
    logic                 accept;
    mmbl_pkg::req_kind_t  kind;
    mmbl_pkg::coord_t     ax;
    mmbl_pkg::coord_t     ay;
    mmbl_pkg::ext_t       ax_ext;
    mmbl_pkg::ext_t       ay_ext;
    mmbl_pkg::ext_t       half_ext;

    assign push       = valid_reg && !q_full;
    assign req_stall  = valid_reg && q_full;
    assign accept     = req_valid && !req_stall;
    assign push_entry = entry_reg;

    // Classify and build the square box
    always_comb
    begin
        kind = mmbl_pkg::req_kind_t'(req_data.req_type);
        ax = mmbl_pkg::sat_coord({{(mmbl_pkg::EXT_WIDTH-mmbl_pkg::IN_COORD_WIDTH)
                                   {req_data.anchor_x[mmbl_pkg::IN_COORD_WIDTH-1]}},
                                  req_data.anchor_x});
        ay = mmbl_pkg::sat_coord({{(mmbl_pkg::EXT_WIDTH-mmbl_pkg::IN_COORD_WIDTH)
                                   {req_data.anchor_y[mmbl_pkg::IN_COORD_WIDTH-1]}},
                                  req_data.anchor_y});
        ax_ext = mmbl_pkg::sext_coord(ax);
        ay_ext = mmbl_pkg::sext_coord(ay);
        if (kind == mmbl_pkg::REQ_NEGATIVE)
            half_ext = {{(mmbl_pkg::EXT_WIDTH-mmbl_pkg::HALF_WIDTH){1'b0}},
                        cfg.negative_half_side};
        else
            half_ext = {{(mmbl_pkg::EXT_WIDTH-mmbl_pkg::HALF_WIDTH){1'b0}},
                        cfg.anchor_half_side};
        entry_next.kind    = kind;
        entry_next.sq.xmin = mmbl_pkg::sat_coord(ax_ext - half_ext);
        entry_next.sq.xmax = mmbl_pkg::sat_coord(ax_ext + half_ext);
        entry_next.sq.ymin = mmbl_pkg::sat_coord(ay_ext - half_ext);
        entry_next.sq.ymax = mmbl_pkg::sat_coord(ay_ext + half_ext);
    end

    // Stage occupancy
    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (push)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mmbl_queue.sv -----
// ============================================================================
// mmbl_queue
// Small FIFO of classified items between the front and the back.
// ============================================================================
`default_nettype none

module mmbl_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire mmbl_pkg::entry_t  push_entry,
    input  wire logic              pop,
    output logic                   full,
    output logic                   head_valid,
    output mmbl_pkg::entry_t       head_entry
);

    mmbl_pkg::entry_t                 slots_reg [mmbl_pkg::QUEUE_DEPTH];
    logic [mmbl_pkg::QPTR_WIDTH-1:0]  wr_ptr_reg;
    logic [mmbl_pkg::QPTR_WIDTH-1:0]  wr_ptr_next;
    logic [mmbl_pkg::QPTR_WIDTH-1:0]  rd_ptr_reg;
    logic [mmbl_pkg::QPTR_WIDTH-1:0]  rd_ptr_next;
    logic [mmbl_pkg::QCNT_WIDTH-1:0]  count_reg;
    logic [mmbl_pkg::QCNT_WIDTH-1:0]  count_next;

    assign full       = (count_reg == mmbl_pkg::QCNT_WIDTH'(mmbl_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slots_reg[rd_ptr_reg];

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == mmbl_pkg::QPTR_WIDTH'(mmbl_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == mmbl_pkg::QPTR_WIDTH'(mmbl_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mmbl_back.sv -----
// ============================================================================
// mmbl_back
// Execution stage: holds the kept box and counts, applies one classified
// item per cycle while the result is not stalled and registers the result transaction.
// ============================================================================
`default_nettype none

module mmbl_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               head_valid,
    input  wire mmbl_pkg::entry_t   head_entry,
    output logic                    pop,
    input  wire mmbl_pkg::reload_t  reload,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output mmbl_pkg::rsp_t          rsp_data
);

    mmbl_pkg::box_t    box_reg;
    mmbl_pkg::box_t    box_next;
    mmbl_pkg::count_t  anchor_cnt_reg;
    mmbl_pkg::count_t  anchor_cnt_next;
    mmbl_pkg::count_t  neigh_cnt_reg;
    mmbl_pkg::count_t  neigh_cnt_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    mmbl_pkg::rsp_t    rsp_reg;
    mmbl_pkg::rsp_t    rsp_next;

    mmbl_pkg::box_t    sq;
    mmbl_pkg::box_t    isect;
    logic              meet;
    mmbl_pkg::count_t  anchor_inc;
    mmbl_pkg::count_t  neigh_inc;
    logic [mmbl_pkg::COUNT_WIDTH:0]  total;
    logic [mmbl_pkg::COORD_WIDTH:0]  sum_x;
    logic [mmbl_pkg::COORD_WIDTH:0]  sum_y;
    logic              lx;
    logic              hx;
    logic              ly;
    logic              hy;
    logic [3:0]        corners;
    logic              est_valid;
    logic              unloc;

    assign pop       = head_valid && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // Item execution
    always_comb
    begin
        sq         = head_entry.sq;
        meet       = mmbl_pkg::boxes_meet(sq, box_reg);
        isect.xmin = mmbl_pkg::smax(box_reg.xmin, sq.xmin);
        isect.ymin = mmbl_pkg::smax(box_reg.ymin, sq.ymin);
        isect.xmax = mmbl_pkg::smin(box_reg.xmax, sq.xmax);
        isect.ymax = mmbl_pkg::smin(box_reg.ymax, sq.ymax);

        anchor_inc = (&anchor_cnt_reg) ? anchor_cnt_reg : anchor_cnt_reg + 1'b1;
        neigh_inc  = (&neigh_cnt_reg) ? neigh_cnt_reg : neigh_cnt_reg + 1'b1;
        total      = {1'b0, anchor_inc} + {1'b0, neigh_cnt_reg};

        lx = (isect.xmin == box_reg.xmin);
        hx = (isect.xmax == box_reg.xmax);
        ly = (isect.ymin == box_reg.ymin);
        hy = (isect.ymax == box_reg.ymax);
        corners = {hx && hy, lx && hy, hx && ly, lx && ly};

        box_next        = box_reg;
        anchor_cnt_next = anchor_cnt_reg;
        neigh_cnt_next  = neigh_cnt_reg;
        est_valid       = 1'b0;
        unloc           = 1'b0;

        unique case (head_entry.kind)
            mmbl_pkg::REQ_ANCHOR:
            begin
                box_next        = meet ? isect : sq;
                anchor_cnt_next = anchor_inc;
                if (total >= (mmbl_pkg::COUNT_WIDTH+1)'(mmbl_pkg::ESTIMATE_MIN_COUNT))
                begin
                    est_valid       = 1'b1;
                    anchor_cnt_next = '0;
                    neigh_cnt_next  = '0;
                end
            end
            mmbl_pkg::REQ_NEIGHBOUR:
                neigh_cnt_next = neigh_inc;
            mmbl_pkg::REQ_NEGATIVE:
            begin
                if (meet)
                begin
                    // two adjacent corners inside trim the side they lie on
                    case (corners)
                        mmbl_pkg::CORNERS_ALL:    unloc         = 1'b1;
                        mmbl_pkg::CORNERS_BOTTOM: box_next.ymin = isect.ymax;
                        mmbl_pkg::CORNERS_LEFT:   box_next.xmin = isect.xmax;
                        mmbl_pkg::CORNERS_RIGHT:  box_next.xmax = isect.xmin;
                        mmbl_pkg::CORNERS_TOP:    box_next.ymax = isect.ymin;
                        default: ;
                    endcase
                end
            end
            mmbl_pkg::REQ_RESERVED: ;
            default: ;
        endcase

        // Box centre, floor of half the sum
        sum_x = {box_next.xmin[mmbl_pkg::COORD_WIDTH-1], box_next.xmin}
              + {box_next.xmax[mmbl_pkg::COORD_WIDTH-1], box_next.xmax};
        sum_y = {box_next.ymin[mmbl_pkg::COORD_WIDTH-1], box_next.ymin}
              + {box_next.ymax[mmbl_pkg::COORD_WIDTH-1], box_next.ymax};

        rsp_next.box_xmin       = box_next.xmin;
        rsp_next.box_xmax       = box_next.xmax;
        rsp_next.box_ymin       = box_next.ymin;
        rsp_next.box_ymax       = box_next.ymax;
        rsp_next.estimate_x     = est_valid ? sum_x[mmbl_pkg::COORD_WIDTH:1] : '0;
        rsp_next.estimate_y     = est_valid ? sum_y[mmbl_pkg::COORD_WIDTH:1] : '0;
        rsp_next.estimate_valid = est_valid;
        rsp_next.unlocalizable  = unloc;
    end

    // Output register occupancy
    always_comb
    begin
        if (pop)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    // Kept box and counts; extent writes reload one axis
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg.xmin   <= '0;
            box_reg.xmax   <= mmbl_pkg::extent_to_coord(mmbl_pkg::FIELD_WIDTH_RST);
            box_reg.ymin   <= '0;
            box_reg.ymax   <= mmbl_pkg::extent_to_coord(mmbl_pkg::FIELD_HEIGHT_RST);
            anchor_cnt_reg <= '0;
            neigh_cnt_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (reload.load_x)
            begin
                box_reg.xmin <= '0;
                box_reg.xmax <= mmbl_pkg::extent_to_coord(reload.extent);
            end
            else if (reload.load_y)
            begin
                box_reg.ymin <= '0;
                box_reg.ymax <= mmbl_pkg::extent_to_coord(reload.extent);
            end
            else if (pop)
            begin
                box_reg        <= box_next;
                anchor_cnt_reg <= anchor_cnt_next;
                neigh_cnt_reg  <= neigh_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            rsp_reg <= rsp_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/minmax_bounding_box_localizer.sv -----
// ============================================================================
// minmax_bounding_box_localizer
// Min-max bounding-box position estimator for one node.
// ============================================================================
// Usage:
//   req channel (req_valid/req_stall/req_data) carries one anchor, neighbour
//   or negative-anchor transaction; rsp channel (rsp_valid/rsp_stall/
//   rsp_data) returns exactly one result per request: the kept box after the
//   item, the centre estimate when issued, and the unlocalizable flag.
//   A transaction moves on a rising edge with valid high and stall low.
//   A taken request is registered in the input stage, moves from there into
//   the queue, and goes from the queue head into the output register.
//   Throughput: one transaction per cycle while rsp is not stalled, set by
//   the execution stage that updates the kept box.
//   A 4-entry queue sits between input and execution stages; a stalled rsp
//   holds its payload, the queue fills, and then req_stall rises.
//   Reset clears the counts and loads the box to (0, field_width, 0,
//   field_height) with the register reset values; no items are in flight.
//   APB writes to an extent register reload that axis of the box; write
//   registers only while no transaction is in flight.
// ============================================================================
`default_nettype none

module minmax_bounding_box_localizer (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                req_valid,
    output logic                                     req_stall,
    input  wire mmbl_pkg::req_t                      req_data,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_stall,
    output mmbl_pkg::rsp_t                           rsp_data,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mmbl_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  wire logic [mmbl_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic      [mmbl_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                     pready
);

    mmbl_pkg::cfg_t     cfg;
    mmbl_pkg::reload_t  reload;
    logic               q_full;
    logic               push;
    mmbl_pkg::entry_t   push_entry;
    logic               pop;
    logic               head_valid;
    mmbl_pkg::entry_t   head_entry;

    mmbl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .reload  (reload)
    );

    mmbl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .cfg        (cfg),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    mmbl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    mmbl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .reload     (reload),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/mmbl_checker.sv -----
// ============================================================================
// mmbl_checker
// Port-level checks of the localizer result channel, bound to the top level.
// ============================================================================
`default_nettype none

module mmbl_checker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            rsp_valid,
    input  wire logic            rsp_stall,
    input  wire mmbl_pkg::rsp_t  rsp_data
);

    // A stalled result stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("rsp transaction changed while stalled");

    // No estimate means a zero centre
    a_est_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.estimate_valid |->
            rsp_data.estimate_x == '0 && rsp_data.estimate_y == '0)
        else $error("centre nonzero without estimate_valid");

    // Estimates come from anchors, the flag from negative anchors
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_data.estimate_valid && rsp_data.unlocalizable))
        else $error("estimate_valid and unlocalizable both set");

endmodule

bind minmax_bounding_box_localizer mmbl_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ============================================================================
// tb_top
// Self-checking bench for the min-max bounding-box localizer. A directed
// sequence covers box intersection and replacement, estimate issue, the
// negative-anchor side trims, the unlocalizable flag, ignored requests and
// coordinate saturation. Random beacon traffic then runs through several
// register settings. A local box predictor computes one expected result per
// accepted request, and each returned result is checked field by field. Both
// channel sides idle at random, and one long result hold-off fills the block.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint COORD_TOP   = (longint'(1) <<< (mmbl_pkg::COORD_WIDTH - 1)) - 1;
    localparam longint COORD_BOT   = -COORD_TOP - 1;
    localparam int     COUNT_TOP   = (1 << mmbl_pkg::COUNT_WIDTH) - 1;
    localparam int     HOLD_CYCLES = 300;

    // Kept box in wide signed integers
    typedef struct {
        longint xlo;
        longint xhi;
        longint ylo;
        longint yhi;
    } span_t;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                req_valid = 1'b0;
    logic                                req_stall;
    mmbl_pkg::req_t                      req_data  = '0;
    logic                                rsp_valid;
    logic                                rsp_stall = 1'b0;
    mmbl_pkg::rsp_t                      rsp_data;
    logic                                psel      = 1'b0;
    logic                                penable   = 1'b0;
    logic                                pwrite    = 1'b0;
    logic [mmbl_pkg::APB_ADDR_WIDTH-1:0] paddr     = '0;
    logic [mmbl_pkg::APB_DATA_WIDTH-1:0] pwdata    = '0;
    logic [mmbl_pkg::APB_DATA_WIDTH-1:0] prdata;
    logic                                pready;

    // Stimulus and expected results
    mmbl_pkg::req_t beacon_queue[$];
    mmbl_pkg::rsp_t expected_boxes[$];
    int unsigned    fault_count  = 0;
    int unsigned    send_gap_max = 0;
    int unsigned    recv_gap_max = 0;
    int unsigned    send_wait    = 0;
    int unsigned    stall_left   = 0;
    int unsigned    hold_asked   = 0;
    int unsigned    hold_seen    = 0;
    int unsigned    hold_left    = 0;

    // Predictor state and register copies
    span_t                             kept;
    int unsigned                       anchors_heard;
    int unsigned                       neighbours_heard;
    logic [mmbl_pkg::EXTENT_WIDTH-1:0] ext_x;
    logic [mmbl_pkg::EXTENT_WIDTH-1:0] ext_y;
    logic [mmbl_pkg::HALF_WIDTH-1:0]   anchor_half;
    logic [mmbl_pkg::HALF_WIDTH-1:0]   negative_half;

    // Last anchor position, keeps random traffic around the box
    longint trail_x;
    longint trail_y;

    minmax_bounding_box_localizer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Box predictor
    // ------------------------------------------------------------------------
    function automatic longint clamp_coord(input longint v);
        if (v > COORD_TOP)
            return COORD_TOP;
        if (v < COORD_BOT)
            return COORD_BOT;
        return v;
    endfunction

    function automatic span_t square_around(input longint cx, input longint cy,
                                            input longint h);
        span_t s;
        s.xlo = clamp_coord(cx - h);
        s.xhi = clamp_coord(cx + h);
        s.ylo = clamp_coord(cy - h);
        s.yhi = clamp_coord(cy + h);
        return s;
    endfunction

    function automatic bit holds_point(input longint px, input longint py, input span_t b);
        return px >= b.xlo && px <= b.xhi && py >= b.ylo && py <= b.yhi;
    endfunction

    // Corner-containment test of a square against the kept box
    function automatic bit boxes_touch(input span_t b);
        return holds_point(b.xlo, b.ylo, kept) || holds_point(b.xlo, b.yhi, kept) ||
               holds_point(b.xhi, b.ylo, kept) || holds_point(b.xhi, b.yhi, kept) ||
               holds_point(kept.xlo, kept.ylo, b) || holds_point(kept.xlo, kept.yhi, b) ||
               holds_point(kept.xhi, kept.ylo, b) || holds_point(kept.xhi, kept.yhi, b);
    endfunction

    function automatic mmbl_pkg::rsp_t predict_locate(input mmbl_pkg::req_t r);
        span_t          sq;
        longint         ax;
        longint         ay;
        longint         ilx;
        longint         ihx;
        longint         ily;
        longint         ihy;
        logic [3:0]     corners;
        mmbl_pkg::rsp_t res;
        res = '0;
        ax  = clamp_coord(longint'(r.anchor_x));
        ay  = clamp_coord(longint'(r.anchor_y));
        case (mmbl_pkg::req_kind_t'(r.req_type))
            mmbl_pkg::REQ_ANCHOR:
            begin
                sq = square_around(ax, ay, longint'(anchor_half));
                if (boxes_touch(sq))
                begin
                    kept.xlo = (sq.xlo > kept.xlo) ? sq.xlo : kept.xlo;
                    kept.ylo = (sq.ylo > kept.ylo) ? sq.ylo : kept.ylo;
                    kept.xhi = (sq.xhi < kept.xhi) ? sq.xhi : kept.xhi;
                    kept.yhi = (sq.yhi < kept.yhi) ? sq.yhi : kept.yhi;
                end
                else
                begin
                    kept = sq;
                end
                if (anchors_heard < COUNT_TOP)
                    anchors_heard++;
                if (anchors_heard + neighbours_heard >= mmbl_pkg::ESTIMATE_MIN_COUNT)
                begin
                    // floor of half the sum
                    res.estimate_x     = mmbl_pkg::coord_t'(
                                             clamp_coord((kept.xlo + kept.xhi) >>> 1));
                    res.estimate_y     = mmbl_pkg::coord_t'(
                                             clamp_coord((kept.ylo + kept.yhi) >>> 1));
                    res.estimate_valid = 1'b1;
                    anchors_heard      = 0;
                    neighbours_heard   = 0;
                end
            end
            mmbl_pkg::REQ_NEIGHBOUR:
            begin
                if (neighbours_heard < COUNT_TOP)
                    neighbours_heard++;
            end
            mmbl_pkg::REQ_NEGATIVE:
            begin
                sq = square_around(ax, ay, longint'(negative_half));
                if (boxes_touch(sq))
                begin
                    ilx = (sq.xlo > kept.xlo) ? sq.xlo : kept.xlo;
                    ily = (sq.ylo > kept.ylo) ? sq.ylo : kept.ylo;
                    ihx = (sq.xhi < kept.xhi) ? sq.xhi : kept.xhi;
                    ihy = (sq.yhi < kept.yhi) ? sq.yhi : kept.yhi;
                    corners = {(ihx == kept.xhi) && (ihy == kept.yhi),
                               (ilx == kept.xlo) && (ihy == kept.yhi),
                               (ihx == kept.xhi) && (ily == kept.ylo),
                               (ilx == kept.xlo) && (ily == kept.ylo)};
                    // two adjacent corners trim one side; a diagonal pair cannot arise
                    case (corners)
                        mmbl_pkg::CORNERS_ALL:    res.unlocalizable = 1'b1;
                        mmbl_pkg::CORNERS_BOTTOM: kept.ylo = ihy;
                        mmbl_pkg::CORNERS_LEFT:   kept.xlo = ihx;
                        mmbl_pkg::CORNERS_RIGHT:  kept.xhi = ilx;
                        mmbl_pkg::CORNERS_TOP:    kept.yhi = ily;
                        default:                  ;
                    endcase
                end
            end
            default: ;
        endcase
        res.box_xmin = mmbl_pkg::coord_t'(kept.xlo);
        res.box_xmax = mmbl_pkg::coord_t'(kept.xhi);
        res.box_ymin = mmbl_pkg::coord_t'(kept.ylo);
        res.box_ymax = mmbl_pkg::coord_t'(kept.yhi);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int unsigned draw_wait(input int unsigned max_wait);
        if (max_wait == 0 || $urandom_range(0, 2) != 0)
            return 0;
        return $urandom_range(0, max_wait);
    endfunction

    function automatic longint near_coord(input longint centre, input longint spread);
        return clamp_coord(centre + longint'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic longint pick_coord(input longint centre, input longint extent);
        logic signed [mmbl_pkg::IN_COORD_WIDTH-1:0] raw;
        case ($urandom_range(0, 9))
            0:
            begin
                raw = mmbl_pkg::IN_COORD_WIDTH'($urandom());
                return raw;
            end
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       return COORD_BOT;
                    1:       return COORD_TOP;
                    2:       return 0;
                    default: return -1;
                endcase
            end
            2, 3:    return near_coord(extent / 2, extent / 2 + extent / 8 + 16);
            default: return near_coord(centre,
                                       longint'(anchor_half) + longint'(negative_half) + 16);
        endcase
    endfunction

    function automatic mmbl_pkg::req_t make_beacon();
        mmbl_pkg::req_t r;
        int unsigned    k;
        k = $urandom_range(0, 19);
        if (k < 8)
            r.req_type = mmbl_pkg::REQ_ANCHOR;
        else if (k < 12)
            r.req_type = mmbl_pkg::REQ_NEIGHBOUR;
        else if (k < 19)
            r.req_type = mmbl_pkg::REQ_NEGATIVE;
        else
            r.req_type = mmbl_pkg::REQ_RESERVED;
        r.anchor_x = mmbl_pkg::IN_COORD_WIDTH'(pick_coord(trail_x, longint'(ext_x)));
        r.anchor_y = mmbl_pkg::IN_COORD_WIDTH'(pick_coord(trail_y, longint'(ext_y)));
        if (r.req_type == mmbl_pkg::REQ_ANCHOR)
        begin
            trail_x = r.anchor_x;
            trail_y = r.anchor_y;
        end
        return r;
    endfunction

    task automatic queue_beacon(input mmbl_pkg::req_kind_t kind, input longint x,
                                input longint y);
        mmbl_pkg::req_t r;
        r.req_type = kind;
        r.anchor_x = mmbl_pkg::IN_COORD_WIDTH'(x);
        r.anchor_y = mmbl_pkg::IN_COORD_WIDTH'(y);
        beacon_queue = {beacon_queue, r};
    endtask

    task automatic queue_random(input int unsigned n);
        repeat (n) beacon_queue = {beacon_queue, make_beacon()};
    endtask

    // Wait until every queued transaction is taken and answered
    task automatic drain_all();
        do
            @(negedge clk);
        while (beacon_queue.size() != 0 || req_valid || expected_boxes.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup then access; predictor copy follows the register
    task automatic write_reg(input mmbl_pkg::reg_index_t idx,
                             input logic [mmbl_pkg::APB_DATA_WIDTH-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            mmbl_pkg::REG_FIELD_WIDTH:
            begin
                ext_x    = val[mmbl_pkg::EXTENT_WIDTH-1:0];
                kept.xlo = 0;
                kept.xhi = clamp_coord(longint'(ext_x));
            end
            mmbl_pkg::REG_FIELD_HEIGHT:
            begin
                ext_y    = val[mmbl_pkg::EXTENT_WIDTH-1:0];
                kept.ylo = 0;
                kept.yhi = clamp_coord(longint'(ext_y));
            end
            mmbl_pkg::REG_ANCHOR_HALF:   anchor_half   = val[mmbl_pkg::HALF_WIDTH-1:0];
            mmbl_pkg::REG_NEGATIVE_HALF: negative_half = val[mmbl_pkg::HALF_WIDTH-1:0];
            default: ;
        endcase
        trail_x = longint'(ext_x) / 2;
        trail_y = longint'(ext_y) / 2;
    endtask

    task automatic write_all(input logic [mmbl_pkg::APB_DATA_WIDTH-1:0] w,
                             input logic [mmbl_pkg::APB_DATA_WIDTH-1:0] h,
                             input logic [mmbl_pkg::APB_DATA_WIDTH-1:0] a,
                             input logic [mmbl_pkg::APB_DATA_WIDTH-1:0] n);
        write_reg(mmbl_pkg::REG_FIELD_WIDTH, w);
        write_reg(mmbl_pkg::REG_FIELD_HEIGHT, h);
        write_reg(mmbl_pkg::REG_ANCHOR_HALF, a);
        write_reg(mmbl_pkg::REG_NEGATIVE_HALF, n);
    endtask

    task automatic note_fault(input string msg);
        fault_count++;
        $display("mismatch @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            note_fault($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Request driver: presents queued transactions, predicts on acceptance
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : beacon_driver
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
            send_wait <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_boxes = {expected_boxes, predict_locate(req_data)};
            if (!req_valid || !req_stall)
            begin
                if (send_wait != 0)
                begin
                    send_wait <= send_wait - 1;
                    req_valid <= 1'b0;
                end
                else if (beacon_queue.size() != 0)
                begin
                    req_data  <= beacon_queue.pop_front();
                    req_valid <= 1'b1;
                    send_wait <= draw_wait(send_gap_max);
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Long result hold-off, counted here
    always @(posedge clk)
    begin : hold_counter
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_seen <= 0;
        end
        else if (hold_seen != hold_asked)
        begin
            hold_seen <= hold_asked;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: random stalls, compares against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        mmbl_pkg::rsp_t want;
        int unsigned    wait_n;
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            wait_n = stall_left;
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_boxes.size() == 0)
                begin
                    note_fault("result transaction with nothing expected");
                end
                else
                begin
                    want = expected_boxes.pop_front();
                    if ($isunknown(rsp_data))
                        note_fault("unknown bits in result transaction");
                    check_field("box_xmin", rsp_data.box_xmin, want.box_xmin);
                    check_field("box_xmax", rsp_data.box_xmax, want.box_xmax);
                    check_field("box_ymin", rsp_data.box_ymin, want.box_ymin);
                    check_field("box_ymax", rsp_data.box_ymax, want.box_ymax);
                    check_field("estimate_x", rsp_data.estimate_x, want.estimate_x);
                    check_field("estimate_y", rsp_data.estimate_y, want.estimate_y);
                    check_field("estimate_valid", rsp_data.estimate_valid,
                                want.estimate_valid);
                    check_field("unlocalizable", rsp_data.unlocalizable,
                                want.unlocalizable);
                end
                wait_n = draw_wait(recv_gap_max);
            end
            else if (wait_n != 0)
            begin
                wait_n--;
            end
            stall_left <= wait_n;
            rsp_stall  <= (wait_n != 0) || (hold_left != 0);
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : sequence_main
        ext_x            = mmbl_pkg::FIELD_WIDTH_RST;
        ext_y            = mmbl_pkg::FIELD_HEIGHT_RST;
        anchor_half      = mmbl_pkg::ANCHOR_HALF_RST;
        negative_half    = mmbl_pkg::NEGATIVE_HALF_RST;
        kept.xlo         = 0;
        kept.xhi         = longint'(mmbl_pkg::FIELD_WIDTH_RST);
        kept.ylo         = 0;
        kept.yhi         = longint'(mmbl_pkg::FIELD_HEIGHT_RST);
        anchors_heard    = 0;
        neighbours_heard = 0;
        trail_x          = longint'(ext_x) / 2;
        trail_y          = longint'(ext_y) / 2;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset registers, box 0..16000 on both axes
        send_gap_max = 3;
        recv_gap_max = 3;
        queue_beacon(mmbl_pkg::REQ_ANCHOR, 8000, 8000);            // intersect
        queue_beacon(mmbl_pkg::REQ_NEIGHBOUR, 5, -5);
        queue_beacon(mmbl_pkg::REQ_ANCHOR, 8800, 8800);            // estimate issued
        queue_beacon(mmbl_pkg::REQ_ANCHOR, COORD_BOT, COORD_BOT);  // replace, low saturation
        queue_beacon(mmbl_pkg::REQ_ANCHOR, COORD_TOP, COORD_TOP);  // replace, high saturation
        queue_beacon(mmbl_pkg::REQ_RESERVED, $urandom_range(0, 9999), -7);
        queue_beacon(mmbl_pkg::REQ_NEGATIVE, COORD_BOT, COORD_TOP); // no overlap
        queue_beacon(mmbl_pkg::REQ_ANCHOR, 0, 0);
        queue_beacon(mmbl_pkg::REQ_ANCHOR, 2000, 2000);            // box 400..1600 square
        queue_beacon(mmbl_pkg::REQ_NEGATIVE, 1000, 0);             // trims bottom
        queue_beacon(mmbl_pkg::REQ_NEGATIVE, 2000, 1400);          // trims right
        queue_beacon(mmbl_pkg::REQ_NEGATIVE, -600, 1400);          // trims left
        queue_beacon(mmbl_pkg::REQ_NEGATIVE, 700, 2600);           // trims top
        queue_beacon(mmbl_pkg::REQ_NEGATIVE, 700, 1300);           // covers all corners
        queue_beacon(mmbl_pkg::REQ_NEGATIVE, 1000, 1600);          // covers all corners
        queue_beacon(mmbl_pkg::REQ_NEIGHBOUR, COORD_TOP, COORD_BOT);
        queue_beacon(mmbl_pkg::REQ_NEIGHBOUR, -1, 0);
        queue_beacon(mmbl_pkg::REQ_ANCHOR, -5001, -3);             // negative centre
        queue_beacon(mmbl_pkg::REQ_RESERVED, COORD_TOP, COORD_TOP);
        queue_beacon(mmbl_pkg::REQ_ANCHOR, 12345, 54321);
        drain_all();

        send_gap_max = 18;
        recv_gap_max = 18;
        queue_random(180);
        drain_all();

        // Everything at zero, no idling on either side
        write_all(0, 0, 0, 0);
        send_gap_max = 0;
        recv_gap_max = 0;
        queue_random(100);
        drain_all();

        // Everything at its maximum
        write_all(32'h007F_FFFF, 32'h007F_FFFF, 32'h003F_FFFF, 32'h003F_FFFF);
        send_gap_max = 18;
        recv_gap_max = 18;
        queue_random(130);
        drain_all();

        // Moderate sizes, then a long result hold-off while requests keep coming
        write_all($urandom_range(1000, 20000), $urandom_range(1000, 20000),
                  $urandom_range(200, 3000), $urandom_range(200, 3000));
        send_gap_max = 8;
        recv_gap_max = 8;
        queue_random(60);
        @(negedge clk);
        hold_asked   <= hold_asked + 1;
        send_gap_max = 0;
        queue_random(140);
        drain_all();

        // Random register values, upper bus bits random too
        write_all($urandom(), $urandom(), $urandom(), $urandom());
        send_gap_max = 18;
        recv_gap_max = 4;
        queue_random(150);
        drain_all();

        // Small field, negative box larger than anchor box
        write_all(3000, 5000, 100, 2000);
        send_gap_max = 4;
        recv_gap_max = 18;
        queue_random(170);
        drain_all();

        repeat (10) @(posedge clk);
        if (expected_boxes.size() != 0)
            note_fault($sformatf("%0d results never arrived", expected_boxes.size()));
        if (fault_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Run limit
    initial
    begin : run_limit
        #3_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/mmbl_pkg.sv
hw/rtl/mmbl_regs.sv
hw/rtl/mmbl_front.sv
hw/rtl/mmbl_queue.sv
hw/rtl/mmbl_back.sv
hw/rtl/minmax_bounding_box_localizer.sv
hw/rtl/mmbl_checker.sv
tb/sv/tb_top.sv
